@@ sv/sm3_stream_hash_assert.svh @@
// Assertion macros used by the port-level checker of the SM3 hash engine.
`ifndef SM3_STREAM_HASH_ASSERT_SVH
`define SM3_STREAM_HASH_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SM3H_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sm3h assertion failed");

// Next-cycle implication.
`define SM3H_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sm3h assertion failed");

`endif

@@ sv/sm3h_pkg.sv @@
// Types, constants and round functions of the SM3 hash engine.
package sm3h_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_e;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [31:0] T_LOW      = 32'h79cc4519;
  localparam logic [31:0] T_HIGH_R16 = 32'h9d8a7a87;  // 0x7a879d8a rotated left by 16
  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [5:0]  LAST_FILL  = 6'd55;

  typedef logic [31:0] word_t;

  localparam word_t IV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  function automatic word_t rol(input word_t x, input int unsigned n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t perm0(input word_t x);
    perm0 = x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic word_t perm1(input word_t x);
    perm1 = x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

endpackage

@@ sv/sm3h_in_if.sv @@
// Input word channel: one op and one message byte.
interface sm3h_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

@@ sv/sm3h_out_if.sv @@
// Output word channel: one digest word with its position.
interface sm3h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

@@ sv/sm3h_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sm3h_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sm3_stream_hash.sv @@
// SM3 hash engine: byte absorb into a word RAM, 64-round compression, digest out.
// Absorb: user bytes are taken in idle; the byte that fills a block starts the
// RAM load, 64 rounds at one round per cycle and the chaining update.
// Finish: padding is fed one byte per cycle (9 to 72 bytes, one or two blocks
// with a compression each), then the 8 digest words leave one per ready cycle.
// Reset clears the control state and loads the standard initial value.
module sm3_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  sm3h_in_if.sink     in_i,
  sm3h_out_if.source  out_o
);

  sm3h_pkg::state_e state_q, state_d;

  logic [5:0]  fill_q;
  logic [63:0] total_q;
  logic [63:0] bits_q;
  logic [23:0] acc_q;
  logic        first_q, lenok_q, pad_q, emit_q;
  logic [4:0]  ld_q;
  logic [5:0]  rnd_q;
  logic [2:0]  idx_q;
  logic [31:0] tj_q;
  sm3h_pkg::word_t cv_q [8];
  sm3h_pkg::word_t r_q [8];
  sm3h_pkg::word_t w_q [16];

  logic        in_fire, out_fire;
  logic        feed_en;
  logic [7:0]  feed_byte;
  logic        blk_full;
  logic        pad_done;
  logic        ram_we, ram_re;
  logic [31:0] ram_rdata;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;

  // Byte feeding: user bytes in idle, padding bytes in the pad state.
  always_comb begin
    feed_en   = 1'b0;
    feed_byte = 8'h00;
    unique case (state_q)
      sm3h_pkg::ST_IDLE: begin
        feed_en   = in_fire & (in_i.op == sm3h_pkg::OP_ABSORB);
        feed_byte = in_i.data_byte;
      end
      sm3h_pkg::ST_PAD: begin
        feed_en = 1'b1;
        if (first_q) begin
          feed_byte = sm3h_pkg::PAD_BYTE;
        end else if (lenok_q && (fill_q > sm3h_pkg::LAST_FILL)) begin
          feed_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];
        end
      end
      default: begin
        feed_en = 1'b0;
      end
    endcase
  end

  assign blk_full = feed_en & (fill_q == 6'd63);
  assign pad_done = (state_q == sm3h_pkg::ST_PAD) & !first_q & lenok_q & (fill_q == 6'd63);
  assign ram_we   = feed_en & (fill_q[1:0] == 2'd3);
  assign ram_re   = (state_q == sm3h_pkg::ST_LOAD) & !ld_q[4];

  sm3h_ram #(.Width(32), .Depth(16)) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[5:2]),
    .wdata_i ({acc_q, feed_byte}),
    .re_i    (ram_re),
    .raddr_i (ld_q[3:0]),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sm3h_pkg::ST_IDLE: begin
        if (blk_full) begin
          state_d = sm3h_pkg::ST_LOAD;
        end else if (in_fire && (in_i.op == sm3h_pkg::OP_FINISH)) begin
          state_d = sm3h_pkg::ST_PAD;
        end
      end
      sm3h_pkg::ST_PAD: begin
        if (blk_full) begin
          state_d = sm3h_pkg::ST_LOAD;
        end
      end
      sm3h_pkg::ST_LOAD: begin
        if (ld_q == 5'd16) begin
          state_d = sm3h_pkg::ST_ROUND;
        end
      end
      sm3h_pkg::ST_ROUND: begin
        if (rnd_q == 6'd63) begin
          state_d = sm3h_pkg::ST_FINAL;
        end
      end
      sm3h_pkg::ST_FINAL: begin
        if (emit_q) begin
          state_d = sm3h_pkg::ST_EMIT;
        end else if (pad_q) begin
          state_d = sm3h_pkg::ST_PAD;
        end else begin
          state_d = sm3h_pkg::ST_IDLE;
        end
      end
      sm3h_pkg::ST_EMIT: begin
        if (out_fire && (idx_q == 3'd7)) begin
          state_d = sm3h_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sm3h_pkg::ST_IDLE;
      end
    endcase
  end

  // Port outputs.
  always_comb begin
    in_i.ready        = (state_q == sm3h_pkg::ST_IDLE);
    out_o.valid       = (state_q == sm3h_pkg::ST_EMIT);
    out_o.digest_word = cv_q[idx_q];
    out_o.word_index  = idx_q;
    out_o.last        = (idx_q == 3'd7);
  end

  // Round datapath.
  logic        rnd_low;
  sm3h_pkg::word_t a12, ss1, ss2, ffv, ggv, tt1, tt2, wnew;

  always_comb begin
    rnd_low = (rnd_q[5:4] == 2'd0);
    a12 = sm3h_pkg::rol(r_q[0], 12);
    ss1 = sm3h_pkg::rol(a12 + r_q[4] + tj_q, 7);
    ss2 = ss1 ^ a12;
    if (rnd_low) begin
      ffv = r_q[0] ^ r_q[1] ^ r_q[2];
      ggv = r_q[4] ^ r_q[5] ^ r_q[6];
    end else begin
      ffv = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
      ggv = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
    end
    tt1  = ffv + r_q[3] + ss2 + (w_q[0] ^ w_q[4]);
    tt2  = ggv + r_q[7] + ss1 + w_q[0];
    wnew = sm3h_pkg::perm1(w_q[0] ^ w_q[7] ^ sm3h_pkg::rol(w_q[13], 15))
         ^ sm3h_pkg::rol(w_q[3], 7) ^ w_q[10];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sm3h_pkg::ST_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      first_q <= 1'b0;
      lenok_q <= 1'b0;
      pad_q   <= 1'b0;
      emit_q  <= 1'b0;
      ld_q    <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        cv_q[i] <= sm3h_pkg::IV[i];
      end
    end else begin
      state_q <= state_d;

      if (feed_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if ((state_q == sm3h_pkg::ST_IDLE) && in_fire) begin
        if (in_i.op == sm3h_pkg::OP_ABSORB) begin
          total_q <= total_q + 64'd1;
        end else begin
          first_q <= 1'b1;
          lenok_q <= 1'b0;
          pad_q   <= 1'b1;
        end
      end
      if (state_q == sm3h_pkg::ST_PAD) begin
        first_q <= 1'b0;
        // Length bytes go in once the block holding them has started.
        if ((fill_q == 6'd63) || (first_q && (fill_q <= sm3h_pkg::LAST_FILL))) begin
          lenok_q <= 1'b1;
        end
        if (pad_done) begin
          pad_q  <= 1'b0;
          emit_q <= 1'b1;
        end
      end

      if (state_q == sm3h_pkg::ST_LOAD) begin
        ld_q <= ld_q + 5'd1;
      end else begin
        ld_q <= '0;
      end
      if (state_q == sm3h_pkg::ST_ROUND) begin
        rnd_q <= rnd_q + 6'd1;
      end

      if (state_q == sm3h_pkg::ST_FINAL) begin
        for (int i = 0; i < 8; i++) begin
          cv_q[i] <= cv_q[i] ^ r_q[i];
        end
      end

      if (out_fire) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          // Restart from the initial value for the next message.
          emit_q  <= 1'b0;
          fill_q  <= '0;
          total_q <= '0;
          for (int i = 0; i < 8; i++) begin
            cv_q[i] <= sm3h_pkg::IV[i];
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (feed_en) begin
      acc_q <= {acc_q[15:0], feed_byte};
    end
    if ((state_q == sm3h_pkg::ST_IDLE) && in_fire) begin
      bits_q <= {total_q[60:0], 3'b000};
    end
    if ((state_q == sm3h_pkg::ST_LOAD) && (ld_q != 5'd0)) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= ram_rdata;
    end else if (state_q == sm3h_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= wnew;
    end
    if (state_q == sm3h_pkg::ST_LOAD) begin
      for (int i = 0; i < 8; i++) begin
        r_q[i] <= cv_q[i];
      end
      tj_q <= sm3h_pkg::T_LOW;
    end else if (state_q == sm3h_pkg::ST_ROUND) begin
      r_q[3] <= r_q[2];
      r_q[2] <= sm3h_pkg::rol(r_q[1], 9);
      r_q[1] <= r_q[0];
      r_q[0] <= tt1;
      r_q[7] <= r_q[6];
      r_q[6] <= sm3h_pkg::rol(r_q[5], 19);
      r_q[5] <= r_q[4];
      r_q[4] <= sm3h_pkg::perm0(tt2);
      tj_q   <= (rnd_q == 6'd15) ? sm3h_pkg::T_HIGH_R16 : sm3h_pkg::rol(tj_q, 1);
    end
  end

endmodule

@@ sv/sm3h_chk.sv @@
// Port-level checker for the SM3 hash engine, bound to the top level.
`include "sm3_stream_hash_assert.svh"

module sm3h_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] word_index_i,
  input logic       last_i
);

  `SM3H_ASSERT_IMP(a_last_idx, clk_i, rst_ni, out_valid_i, last_i == (word_index_i == 3'd7))
  `SM3H_ASSERT_IMP(a_no_accept_emit, clk_i, rst_ni, out_valid_i, !in_ready_i)
  `SM3H_ASSERT_NXT(a_next_word, clk_i, rst_ni, out_valid_i && out_ready_i && !last_i,
                   out_valid_i && (word_index_i == $past(word_index_i) + 3'd1))
  `SM3H_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(word_index_i))

endmodule

bind sm3_stream_hash sm3h_chk u_sm3h_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .word_index_i (out_o.word_index),
  .last_i       (out_o.last)
);

@@ tb/sv/sm3_stream_hash_checker.sv @@
// Checker for the SM3 hash engine: predicts digest words and compares them.
`timescale 1ns / 100ps

module sm3_stream_hash_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  sm3h_in_if     in_i,
  sm3h_out_if    out_i,
  output int     fail_count_o,
  output int     digest_pending_o
);

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] START_CV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  digest_word_t digest_q[$];
  logic [31:0]  chain_v [8];
  logic [7:0]   msg_buf [64];
  int unsigned  msg_fill;
  logic [63:0]  msg_bytes;
  int           fail_count;
  int           digest_pending;

  assign fail_count_o     = fail_count;
  assign digest_pending_o = digest_pending;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    int unsigned k;
    k = n % 32;
    if (k == 0) begin
      return x;
    end
    return (x << k) | (x >> (32 - k));
  endfunction

  // Fold one 64-byte block into the chaining value.
  function automatic void compress_block(input logic [7:0] blk [128], input int unsigned base);
    logic [31:0] w [68];
    logic [31:0] r [8];
    logic [31:0] a12, s1, s2, ff, gg, t1, t2, tj;
    for (int j = 0; j < 16; j++) begin
      w[j] = {blk[base + 4*j], blk[base + 4*j + 1], blk[base + 4*j + 2], blk[base + 4*j + 3]};
    end
    for (int j = 16; j < 68; j++) begin
      t1 = w[j-16] ^ w[j-9] ^ rotl32(w[j-3], 15);
      w[j] = t1 ^ rotl32(t1, 15) ^ rotl32(t1, 23) ^ rotl32(w[j-13], 7) ^ w[j-6];
    end
    for (int j = 0; j < 8; j++) begin
      r[j] = chain_v[j];
    end
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
      a12 = rotl32(r[0], 12);
      s1  = rotl32(a12 + r[4] + rotl32(tj, j), 7);
      s2  = s1 ^ a12;
      if (j < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      t1 = ff + r[3] + s2 + (w[j] ^ w[j+4]);
      t2 = gg + r[7] + s1 + w[j];
      r[3] = r[2];
      r[2] = rotl32(r[1], 9);
      r[1] = r[0];
      r[0] = t1;
      r[7] = r[6];
      r[6] = rotl32(r[5], 19);
      r[5] = r[4];
      r[4] = t2 ^ rotl32(t2, 9) ^ rotl32(t2, 17);
    end
    for (int j = 0; j < 8; j++) begin
      chain_v[j] = chain_v[j] ^ r[j];
    end
  endfunction

  function automatic void restart_message();
    for (int j = 0; j < 8; j++) begin
      chain_v[j] = START_CV[j];
    end
    msg_fill  = 0;
    msg_bytes = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [7:0] blk [128];
    msg_buf[msg_fill] = b;
    msg_fill++;
    msg_bytes = msg_bytes + 64'd1;
    if (msg_fill == 64) begin
      for (int j = 0; j < 64; j++) begin
        blk[j] = msg_buf[j];
      end
      compress_block(blk, 0);
      msg_fill = 0;
    end
  endfunction

  // Pad, compress the tail and queue the eight digest words.
  function automatic void finish_message();
    logic [7:0]  tail [128];
    logic [63:0] bit_len;
    int unsigned span;
    digest_word_t dw;
    span = (msg_fill <= 55) ? 64 : 128;
    for (int j = 0; j < 128; j++) begin
      tail[j] = (j < msg_fill) ? msg_buf[j] : 8'h00;
    end
    tail[msg_fill] = 8'h80;
    bit_len = msg_bytes << 3;
    for (int j = 0; j < 8; j++) begin
      tail[span - 1 - j] = bit_len[8*j +: 8];
    end
    compress_block(tail, 0);
    if (span == 128) begin
      compress_block(tail, 64);
    end
    for (int j = 0; j < 8; j++) begin
      dw.digest_word = chain_v[j];
      dw.word_index  = 3'(j);
      dw.last        = (j == 7);
      digest_q.push_back(dw);
    end
    restart_message();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t want;
    if (!rst_ni) begin
      restart_message();
      digest_q.delete();
      fail_count     = 0;
      digest_pending = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        if (in_i.op == sm3h_pkg::OP_FINISH) begin
          finish_message();
        end else begin
          absorb_byte(in_i.data_byte);
        end
      end
      if (out_i.valid && out_i.ready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected digest word %h index %0d last %b", out_i.digest_word,
                     out_i.word_index, out_i.last);
          end
        end else begin
          want = digest_q.pop_front();
          if (out_i.digest_word !== want.digest_word || out_i.word_index !== want.word_index
              || out_i.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                       want.digest_word, want.word_index, want.last,
                       out_i.digest_word, out_i.word_index, out_i.last);
            end
          end
        end
      end
      digest_pending = digest_q.size();
    end
  end

endmodule

@@ tb/sv/sm3_stream_hash_test.sv @@
// Testbench top for the SM3 hash engine: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module sm3_stream_hash_test;

  localparam int CYCLE_LIMIT = 600000;
  localparam int unsigned ITEM_COUNT = 480;

  logic clk_i;
  logic rst_ni;
  logic no_idle;
  int   fail_count;
  int   digest_pending;
  int   cycle_count;
  int unsigned sent_words;

  sm3h_in_if  in_ch ();
  sm3h_out_if out_ch ();

  sm3_stream_hash uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sm3_stream_hash_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_ch),
    .out_i            (out_ch),
    .fail_count_o     (fail_count),
    .digest_pending_o (digest_pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sm3_stream_hash");
      $finish;
    end
  end

  // Stall the digest side at random, except while no_idle is set.
  always @(posedge clk_i) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 23);
  end

  task automatic send_word(input logic op, input logic [7:0] b);
    if (!no_idle && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    sent_words++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      send_word(sm3h_pkg::OP_ABSORB, 8'($urandom));
    end
    send_word(sm3h_pkg::OP_FINISH, 8'($urandom));
  endtask

  initial begin
    int unsigned len;
    cycle_count     = 0;
    sent_words      = 0;
    no_idle         = 1'b0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = sm3h_pkg::OP_ABSORB;
    in_ch.data_byte = 8'h00;
    out_ch.ready    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message, then a second finish right after it.
    send_word(sm3h_pkg::OP_FINISH, 8'hff);
    send_word(sm3h_pkg::OP_FINISH, 8'h00);
    // "abc"
    send_word(sm3h_pkg::OP_ABSORB, 8'h61);
    send_word(sm3h_pkg::OP_ABSORB, 8'h62);
    send_word(sm3h_pkg::OP_ABSORB, 8'h63);
    send_word(sm3h_pkg::OP_FINISH, 8'h00);
    send_word(sm3h_pkg::OP_ABSORB, 8'h00);
    send_word(sm3h_pkg::OP_FINISH, 8'h00);
    send_word(sm3h_pkg::OP_ABSORB, 8'hff);
    send_word(sm3h_pkg::OP_FINISH, 8'hff);

    // Hold until the engine has drained every digest word.
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (digest_pending == 0);
    repeat (20) @(posedge clk_i);

    // Padding boundaries: one or two tail blocks, exact full blocks.
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);

    while (sent_words < ITEM_COUNT) begin
      no_idle = (sent_words >= 300 && sent_words < 420);
      case ($urandom_range(9))
        0:       len = $urandom_range(200, 120);
        1, 2:    len = $urandom_range(70, 50);
        default: len = $urandom_range(20);
      endcase
      if (sent_words + len + 1 > ITEM_COUNT) begin
        len = ITEM_COUNT - sent_words - 1;
      end
      send_message(len);
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    wait (digest_pending == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS sm3_stream_hash");
    end else begin
      $display("FAIL sm3_stream_hash");
    end
    $finish;
  end

endmodule
